FILE: rtl/core/cht_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the chained hash table engine.
// No dependencies; used by the interfaces, the modulo unit and the top level.
package cht_pkg;

   localparam int BUCKETS = 4096;
   localparam int NODES   = 8192;

   localparam int BKT_W   = $clog2(BUCKETS);
   localparam int NODE_W  = $clog2(NODES);
   localparam int CNT_W   = $clog2(NODES + 1);
   localparam int BCNT_W  = 13;
   localparam int WORD_W  = 32;

   // dividend bits consumed per cycle by the modulo unit
   localparam int MOD_RADIX_BITS = 4;
   localparam int MOD_STEPS      = WORD_W / MOD_RADIX_BITS;
   localparam int MOD_CNT_W      = $clog2(MOD_STEPS);

   localparam logic [WORD_W-1:0] DELETED_CODE = '1;

   typedef enum logic [1:0] {
      FN_ADD    = 2'd0,
      FN_FIND   = 2'd1,
      FN_DELETE = 2'd2,
      FN_CLEAR  = 2'd3
   } func_type;

   typedef enum logic [2:0] {
      ST_ADDED   = 3'd0,
      ST_UPDATED = 3'd1,
      ST_FULL    = 3'd2,
      ST_HIT     = 3'd3,
      ST_MISS    = 3'd4,
      ST_CLEARED = 3'd5
   } status_type;

   typedef struct packed {
      logic              valid;
      logic [NODE_W-1:0] idx;
   } head_type;

   typedef struct packed {
      logic [WORD_W-1:0] sign_high;
      logic [WORD_W-1:0] sign_low;
      logic [WORD_W-1:0] code;
      logic [WORD_W-1:0] value;
      logic              link_valid;
      logic [NODE_W-1:0] link;
   } node_type;

   typedef struct packed {
      logic              start;
      logic [WORD_W-1:0] dividend;
      logic [BCNT_W-1:0] divisor;
   } mod_req_type;

   typedef struct packed {
      logic              busy;
      logic              done;
      logic [BCNT_W-1:0] remainder;
   } mod_rsp_type;

endpackage

FILE: rtl/core/cht_ifs.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces of the chained hash table engine.
// Depends on cht_pkg for field widths.
interface cht_req_if;
   logic                              valid;
   logic                              ready;
   logic [1:0]                        func;
   logic [cht_pkg::WORD_W-1:0]        sign_high;
   logic [cht_pkg::WORD_W-1:0]        sign_low;
   logic signed [cht_pkg::WORD_W-1:0] code_in;
   logic signed [cht_pkg::WORD_W-1:0] value_in;
   modport source (output valid, func, sign_high, sign_low, code_in, value_in, input ready);
   modport sink   (input valid, func, sign_high, sign_low, code_in, value_in, output ready);
endinterface

interface cht_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [2:0]                        status;
   logic signed [cht_pkg::WORD_W-1:0] code_out;
   logic signed [cht_pkg::WORD_W-1:0] value_out;
   modport source (output valid, status, code_out, value_out, input ready);
   modport sink   (input valid, status, code_out, value_out, output ready);
endinterface

interface cht_csr_if;
   logic                       valid;
   logic                       ready;
   logic [cht_pkg::BCNT_W-1:0] bucket_count;
   modport source (output valid, bucket_count, input ready);
   modport sink   (input valid, bucket_count, output ready);
endinterface

FILE: rtl/core/cht_mod.sv
`timescale 1ns / 1ps
// Iterative modulo unit: 32-bit dividend mod 13-bit divisor, radix-16 restoring.
// Depends on cht_pkg.
module cht_mod (
   input  logic                 clock,
   input  logic                 reset,
   input  cht_pkg::mod_req_type mod_req,
   output cht_pkg::mod_rsp_type mod_rsp
);

   logic                            busy_ff, busy_in;
   logic                            done_ff, done_in;
   logic [cht_pkg::MOD_CNT_W-1:0]   cnt_ff, cnt_in;
   logic [cht_pkg::WORD_W-1:0]      dvd_ff, dvd_in;
   logic [cht_pkg::BCNT_W-1:0]      div_ff, div_in;
   logic [cht_pkg::BCNT_W-1:0]      rem_ff, rem_in;
   logic [cht_pkg::BCNT_W-1:0]      rem_step;

   always_comb begin
      logic [cht_pkg::BCNT_W:0] t;
      rem_step = rem_ff;
      for (int k = 0; k < cht_pkg::MOD_RADIX_BITS; k++) begin
         t = {rem_step, dvd_ff[cht_pkg::WORD_W-1-k]};
         if (t >= {1'b0, div_ff}) begin
            t = t - {1'b0, div_ff};
         end
         rem_step = t[cht_pkg::BCNT_W-1:0];
      end
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      div_in  = div_ff;
      rem_in  = rem_ff;
      if (mod_req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         dvd_in  = mod_req.dividend;
         div_in  = mod_req.divisor;
         rem_in  = '0;
      end else if (busy_ff) begin
         rem_in = rem_step;
         dvd_in = dvd_ff << cht_pkg::MOD_RADIX_BITS;
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == cht_pkg::MOD_CNT_W'(cht_pkg::MOD_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      dvd_ff <= dvd_in;
      div_ff <= div_in;
      rem_ff <= rem_in;
   end

   assign mod_rsp.busy      = busy_ff;
   assign mod_rsp.done      = done_ff;
   assign mod_rsp.remainder = rem_ff;

   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff)) else $error("modulo done without a running division");
   a_rem_below_div: assert property (@(posedge clock) disable iff (reset)
      (done_ff && div_ff != '0) |-> (rem_ff < div_ff)) else $error("remainder not below divisor");
   a_no_start_busy: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> !done_ff) else $error("busy and done together");

endmodule

FILE: rtl/core/chained_hash_table_engine.sv
`timescale 1ns / 1ps
// Chained hash table engine: bucket head memory, node pool memory, walk sequencer.
// Depends on cht_pkg, the cht_*_if interfaces and cht_mod.
//
// One transaction is processed at a time. Add, find and delete compute the bucket
// index in the modulo unit (4 dividend bits per cycle), read the bucket head, walk
// the chain with one node memory read per cycle, then write back and load the
// result register. Clear, and the period right after reset, sweep all 4096
// entries of the bucket head memory one entry per cycle, during which no request
// is taken. The bucket count register may be written at any time the block is
// idle; the result register lets a new request in while a result waits.
module chained_hash_table_engine (
   input logic        clock,
   input logic        reset,
   cht_req_if.sink    req_bus,
   cht_rsp_if.source  rsp_bus,
   cht_csr_if.sink    csr_bus
);

   typedef enum logic [2:0] {
      S_CLR, S_IDLE, S_DIV, S_HWAIT, S_NWAIT, S_ACT, S_RESP
   } state_type;

   state_type                       state_ff;
   logic [cht_pkg::BCNT_W-1:0]      bucket_count_ff;
   logic [cht_pkg::BKT_W-1:0]       clr_idx_ff;
   logic                            clr_reply_ff;
   logic [cht_pkg::CNT_W-1:0]       nodes_used_ff;
   logic [1:0]                      func_ff;
   logic [cht_pkg::WORD_W-1:0]      sign_high_ff, sign_low_ff, code_ff, value_ff;
   logic [cht_pkg::BKT_W-1:0]       bucket_ff;
   cht_pkg::head_type               head_ff;
   logic [cht_pkg::NODE_W-1:0]      node_idx_ff;
   logic                            found_ff;
   logic [2:0]                      res_status_ff;
   logic [cht_pkg::WORD_W-1:0]      res_code_ff, res_value_ff;
   logic                            rsp_valid_ff;
   logic [2:0]                      rsp_status_ff;
   logic [cht_pkg::WORD_W-1:0]      rsp_code_ff, rsp_value_ff;

   cht_pkg::head_type               head_mem [cht_pkg::BUCKETS];
   cht_pkg::node_type               node_mem [cht_pkg::NODES];
   cht_pkg::head_type               head_rd_ff;
   cht_pkg::node_type               node_rd_ff;

   logic                            req_fire;
   logic [cht_pkg::BCNT_W-1:0]      b_eff;
   cht_pkg::mod_req_type            mod_req;
   cht_pkg::mod_rsp_type            mod_rsp;

   logic                            head_we, head_re, node_we, node_re;
   logic [cht_pkg::BKT_W-1:0]       head_waddr, head_raddr;
   cht_pkg::head_type               head_wdata;
   logic [cht_pkg::NODE_W-1:0]      node_waddr, node_raddr;
   cht_pkg::node_type               node_wdata;
   logic                            node_match;
   logic                            insert;

   assign req_bus.ready = (state_ff == S_IDLE);
   assign req_fire      = req_bus.valid && req_bus.ready;
   assign csr_bus.ready = 1'b1;

   always_comb begin
      b_eff = bucket_count_ff;
      if (bucket_count_ff == '0) begin
         b_eff = cht_pkg::BCNT_W'(1);
      end else if (bucket_count_ff > cht_pkg::BCNT_W'(cht_pkg::BUCKETS)) begin
         b_eff = cht_pkg::BCNT_W'(cht_pkg::BUCKETS);
      end
   end

   assign mod_req.start    = req_fire && (req_bus.func != cht_pkg::FN_CLEAR);
   assign mod_req.dividend = req_bus.sign_high + req_bus.sign_low;
   assign mod_req.divisor  = b_eff;

   cht_mod u_mod (
      .clock   (clock),
      .reset   (reset),
      .mod_req (mod_req),
      .mod_rsp (mod_rsp)
   );

   assign node_match = (node_rd_ff.sign_high == sign_high_ff)
                    && (node_rd_ff.sign_low == sign_low_ff);
   assign insert     = (state_ff == S_ACT) && (func_ff == cht_pkg::FN_ADD) && !found_ff
                    && (nodes_used_ff < cht_pkg::CNT_W'(cht_pkg::NODES));

   // memory port control
   always_comb begin
      head_we    = 1'b0;
      head_waddr = bucket_ff;
      head_wdata = '{valid: 1'b1, idx: nodes_used_ff[cht_pkg::NODE_W-1:0]};
      head_re    = 1'b0;
      head_raddr = mod_rsp.remainder[cht_pkg::BKT_W-1:0];
      node_we    = 1'b0;
      node_waddr = node_idx_ff;
      node_wdata = node_rd_ff;
      node_re    = 1'b0;
      node_raddr = head_rd_ff.idx;
      case (state_ff)
         S_CLR: begin
            head_we    = 1'b1;
            head_waddr = clr_idx_ff;
            head_wdata = '0;
         end
         S_DIV: begin
            head_re = mod_rsp.done;
         end
         S_HWAIT: begin
            node_re = 1'b1;
         end
         S_NWAIT: begin
            // a matching node stays in node_rd_ff for the write back
            node_re    = !node_match;
            node_raddr = node_rd_ff.link;
         end
         S_ACT: begin
            if (insert) begin
               head_we    = 1'b1;
               node_we    = 1'b1;
               node_waddr = nodes_used_ff[cht_pkg::NODE_W-1:0];
               node_wdata = '{sign_high: sign_high_ff, sign_low: sign_low_ff,
                              code: code_ff, value: value_ff,
                              link_valid: head_ff.valid, link: head_ff.idx};
            end else if (found_ff && func_ff == cht_pkg::FN_ADD) begin
               node_we          = 1'b1;
               node_wdata.code  = code_ff;
               node_wdata.value = value_ff;
            end else if (found_ff && func_ff == cht_pkg::FN_DELETE) begin
               node_we         = 1'b1;
               node_wdata.code = cht_pkg::DELETED_CODE;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (head_we) begin
         head_mem[head_waddr] <= head_wdata;
      end
      if (head_re) begin
         head_rd_ff <= head_mem[head_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (node_we) begin
         node_mem[node_waddr] <= node_wdata;
      end
      if (node_re) begin
         node_rd_ff <= node_mem[node_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_CLR;
         clr_idx_ff      <= '0;
         clr_reply_ff    <= 1'b0;
         nodes_used_ff   <= '0;
         bucket_count_ff <= cht_pkg::BCNT_W'(cht_pkg::BUCKETS);
         rsp_valid_ff    <= 1'b0;
         found_ff        <= 1'b0;
      end else begin
         if (csr_bus.valid) begin
            bucket_count_ff <= csr_bus.bucket_count;
         end
         if (rsp_valid_ff && rsp_bus.ready && state_ff != S_RESP) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_CLR: begin
               clr_idx_ff <= clr_idx_ff + 1'b1;
               if (clr_idx_ff == cht_pkg::BKT_W'(cht_pkg::BUCKETS - 1)) begin
                  res_status_ff <= cht_pkg::ST_CLEARED;
                  res_code_ff   <= '0;
                  res_value_ff  <= '0;
                  state_ff      <= clr_reply_ff ? S_RESP : S_IDLE;
               end
            end
            S_IDLE: begin
               if (req_fire) begin
                  func_ff      <= req_bus.func;
                  sign_high_ff <= req_bus.sign_high;
                  sign_low_ff  <= req_bus.sign_low;
                  code_ff      <= req_bus.code_in;
                  value_ff     <= req_bus.value_in;
                  found_ff     <= 1'b0;
                  if (req_bus.func == cht_pkg::FN_CLEAR) begin
                     clr_idx_ff    <= '0;
                     clr_reply_ff  <= 1'b1;
                     nodes_used_ff <= '0;
                     state_ff      <= S_CLR;
                  end else begin
                     state_ff <= S_DIV;
                  end
               end
            end
            S_DIV: begin
               if (mod_rsp.done) begin
                  bucket_ff <= mod_rsp.remainder[cht_pkg::BKT_W-1:0];
                  state_ff  <= S_HWAIT;
               end
            end
            S_HWAIT: begin
               head_ff     <= head_rd_ff;
               node_idx_ff <= head_rd_ff.idx;
               if (head_rd_ff.valid
                   && {1'b0, head_rd_ff.idx} < cht_pkg::CNT_W'(nodes_used_ff)) begin
                  state_ff <= S_NWAIT;
               end else begin
                  state_ff <= S_ACT;
               end
            end
            S_NWAIT: begin
               if (node_match) begin
                  found_ff <= 1'b1;
                  state_ff <= S_ACT;
               end else if (node_rd_ff.link_valid
                            && {1'b0, node_rd_ff.link} < nodes_used_ff) begin
                  node_idx_ff <= node_rd_ff.link;
               end else begin
                  state_ff <= S_ACT;
               end
            end
            S_ACT: begin
               res_code_ff  <= '0;
               res_value_ff <= '0;
               case (func_ff)
                  cht_pkg::FN_ADD: begin
                     if (found_ff) begin
                        res_status_ff <= cht_pkg::ST_UPDATED;
                     end else if (insert) begin
                        res_status_ff <= cht_pkg::ST_ADDED;
                        nodes_used_ff <= nodes_used_ff + 1'b1;
                     end else begin
                        res_status_ff <= cht_pkg::ST_FULL;
                     end
                  end
                  cht_pkg::FN_FIND: begin
                     res_status_ff <= found_ff ? cht_pkg::ST_HIT : cht_pkg::ST_MISS;
                     if (found_ff) begin
                        res_code_ff  <= node_rd_ff.code;
                        res_value_ff <= node_rd_ff.value;
                     end
                  end
                  default: begin
                     res_status_ff <= found_ff ? cht_pkg::ST_HIT : cht_pkg::ST_MISS;
                  end
               endcase
               state_ff <= S_RESP;
            end
            S_RESP: begin
               if (!rsp_valid_ff || rsp_bus.ready) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_status_ff <= res_status_ff;
                  rsp_code_ff   <= res_code_ff;
                  rsp_value_ff  <= res_value_ff;
                  state_ff      <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.status    = rsp_status_ff;
   assign rsp_bus.code_out  = rsp_code_ff;
   assign rsp_bus.value_out = rsp_value_ff;

   a_pool_bound: assert property (@(posedge clock) disable iff (reset)
      nodes_used_ff <= cht_pkg::CNT_W'(cht_pkg::NODES)) else $error("node pool overrun");
   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      insert |=> (nodes_used_ff == $past(nodes_used_ff) + 1'b1))
      else $error("insert did not take a pool node");
   a_found_only_on_match: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_NWAIT && !node_match) |=> !$rose(found_ff))
      else $error("hit flagged without a signature match");
   a_div_done_in_div: assert property (@(posedge clock) disable iff (reset)
      mod_rsp.done |-> (state_ff == S_DIV)) else $error("bucket index arrived out of sequence");

endmodule

FILE: sim/tb_chained_hash_table_engine.sv
`timescale 1ns / 1ps
// Self-checking testbench of chained_hash_table_engine: random and directed add/find/delete/clear.
// Depends on cht_pkg, the cht_*_if interfaces and the engine RTL.

class hash_table_scoreboard;
   int unsigned         bucket_count;
   logic [31:0]         key_high  [cht_pkg::NODES];
   logic [31:0]         key_low   [cht_pkg::NODES];
   logic [31:0]         code_mem  [cht_pkg::NODES];
   logic [31:0]         value_mem [cht_pkg::NODES];
   int unsigned         next_node [cht_pkg::NODES];
   bit                  next_ok   [cht_pkg::NODES];
   int unsigned         head_node [cht_pkg::BUCKETS];
   bit                  head_ok   [cht_pkg::BUCKETS];
   int unsigned         nodes_used;
   cht_pkg::status_type exp_status[$];
   logic [31:0]         exp_code  [$];
   logic [31:0]         exp_value [$];
   int unsigned         errors;
   int unsigned         checked;

   function new();
      bucket_count = cht_pkg::BUCKETS;
      errors       = 0;
      checked      = 0;
      wipe_table();
   endfunction

   function void wipe_table();
      foreach (head_ok[i]) head_ok[i] = 0;
      foreach (next_ok[i]) next_ok[i] = 0;
      nodes_used = 0;
   endfunction

   function int unsigned bucket_index(logic [31:0] hi, logic [31:0] lo);
      int unsigned divisor;
      logic [31:0] sum;
      divisor = bucket_count;
      if (divisor == 0) divisor = 1;
      if (divisor > cht_pkg::BUCKETS) divisor = cht_pkg::BUCKETS;
      sum = hi + lo;
      return sum % divisor;
   endfunction

   // first node from the bucket head whose two key words match, or -1
   function int find_node(int unsigned bkt, logic [31:0] hi, logic [31:0] lo);
      int unsigned n;
      int unsigned steps;
      if (!head_ok[bkt]) return -1;
      n = head_node[bkt];
      steps = 0;
      while (n < nodes_used && steps < cht_pkg::NODES) begin
         if (key_high[n] == hi && key_low[n] == lo) return n;
         if (!next_ok[n]) break;
         n = next_node[n];
         steps++;
      end
      return -1;
   endfunction

   function void note_request(cht_pkg::func_type fn, logic [31:0] hi, logic [31:0] lo,
                              logic [31:0] code, logic [31:0] value);
      int unsigned         bkt;
      int                  hit;
      cht_pkg::status_type st;
      logic [31:0]         c_out;
      logic [31:0]         v_out;
      bkt   = bucket_index(hi, lo);
      st    = cht_pkg::ST_MISS;
      c_out = '0;
      v_out = '0;
      case (fn)
         cht_pkg::FN_ADD: begin
            hit = find_node(bkt, hi, lo);
            if (hit >= 0) begin
               code_mem[hit]  = code;
               value_mem[hit] = value;
               st = cht_pkg::ST_UPDATED;
            end else if (nodes_used >= cht_pkg::NODES) begin
               st = cht_pkg::ST_FULL;
            end else begin
               key_high[nodes_used]  = hi;
               key_low[nodes_used]   = lo;
               code_mem[nodes_used]  = code;
               value_mem[nodes_used] = value;
               next_node[nodes_used] = head_node[bkt];
               next_ok[nodes_used]   = head_ok[bkt];
               head_node[bkt] = nodes_used;
               head_ok[bkt]   = 1;
               nodes_used++;
               st = cht_pkg::ST_ADDED;
            end
         end
         cht_pkg::FN_FIND: begin
            hit = find_node(bkt, hi, lo);
            if (hit >= 0) begin
               st    = cht_pkg::ST_HIT;
               c_out = code_mem[hit];
               v_out = value_mem[hit];
            end
         end
         cht_pkg::FN_DELETE: begin
            hit = find_node(bkt, hi, lo);
            if (hit >= 0) begin
               code_mem[hit] = cht_pkg::DELETED_CODE;
               st = cht_pkg::ST_HIT;
            end
         end
         default: begin
            wipe_table();
            st = cht_pkg::ST_CLEARED;
         end
      endcase
      exp_status.push_back(st);
      exp_code.push_back(c_out);
      exp_value.push_back(v_out);
   endfunction

   task report(string what, logic [31:0] got, logic [31:0] want);
      errors++;
      $display("mismatch on result %0d: %s got %h expected %h", checked, what, got, want);
   endtask

   task check_response(logic [2:0] st, logic [31:0] c_out, logic [31:0] v_out);
      if (exp_status.size() == 0) begin
         report("unexpected transaction, status", 32'(st), 32'd0);
      end else begin
         if (st !== exp_status[0]) report("status", 32'(st), 32'(exp_status[0]));
         if (c_out !== exp_code[0]) report("code_out", c_out, exp_code[0]);
         if (v_out !== exp_value[0]) report("value_out", v_out, exp_value[0]);
         void'(exp_status.pop_front());
         void'(exp_code.pop_front());
         void'(exp_value.pop_front());
      end
      checked++;
   endtask

   function int unsigned pending();
      return exp_status.size();
   endfunction
endclass

module tb_chained_hash_table_engine;
   localparam int unsigned CYCLE_LIMIT = 4_000_000;

   logic clock;
   logic reset;
   int unsigned cycles;
   int unsigned sent;
   int unsigned rsp_stall;
   logic [31:0] key_pool_hi [32];
   logic [31:0] key_pool_lo [32];

   cht_req_if req_if();
   cht_rsp_if rsp_if();
   cht_csr_if csr_if();

   hash_table_scoreboard table_sb;

   chained_hash_table_engine u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_if),
      .rsp_bus (rsp_if),
      .csr_bus (csr_if)
   );

   initial begin
      clock = 0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("tb_chained_hash_table_engine NOT OK");
         $finish;
      end
   end

   // result side: random ready stall, possibly none, after each transaction
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_if.valid && rsp_if.ready) begin
            table_sb.check_response(rsp_if.status, rsp_if.code_out, rsp_if.value_out);
            rsp_stall = $urandom_range(0, 3);
            rsp_if.ready <= (rsp_stall == 0);
         end else if (rsp_stall > 0) begin
            rsp_stall--;
            rsp_if.ready <= (rsp_stall == 0);
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   task send_req(cht_pkg::func_type fn, logic [31:0] hi, logic [31:0] lo,
                 logic [31:0] code, logic [31:0] value);
      int unsigned gap;
      gap = $urandom_range(0, 3);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid     <= 1'b1;
      req_if.func      <= fn;
      req_if.sign_high <= hi;
      req_if.sign_low  <= lo;
      req_if.code_in   <= code;
      req_if.value_in  <= value;
      do @(posedge clock); while (!req_if.ready);
      table_sb.note_request(fn, hi, lo, code, value);
      sent++;
   endtask

   task wait_idle();
      req_if.valid <= 1'b0;
      while (table_sb.pending() > 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   // waits until the block is idle before writing
   task write_bucket_count(logic [12:0] count);
      wait_idle();
      csr_if.valid        <= 1'b1;
      csr_if.bucket_count <= count;
      do @(posedge clock); while (!csr_if.ready);
      csr_if.valid <= 1'b0;
      table_sb.bucket_count = 32'(count);
   endtask

   task random_phase(int unsigned count);
      int unsigned       pick;
      int unsigned       k;
      logic [31:0]       hi;
      logic [31:0]       lo;
      cht_pkg::func_type fn;
      repeat (count) begin
         pick = $urandom_range(0, 99);
         if (pick < 42)      fn = cht_pkg::FN_ADD;
         else if (pick < 75) fn = cht_pkg::FN_FIND;
         else if (pick < 97) fn = cht_pkg::FN_DELETE;
         else                fn = cht_pkg::FN_CLEAR;
         k = $urandom_range(0, 39);
         if (k < 32) begin
            hi = key_pool_hi[k];
            lo = key_pool_lo[k];
         end else if (k < 36) begin
            // same word sum as a pool key, different words: same bucket, no match
            hi = key_pool_hi[k - 32] + 32'd1;
            lo = key_pool_lo[k - 32] - 32'd1;
         end else begin
            hi = $urandom();
            lo = $urandom();
         end
         send_req(fn, hi, lo, $urandom(), $urandom());
      end
   endtask

   initial begin
      logic [12:0] count_set [6];
      cycles       = 0;
      sent         = 0;
      rsp_stall    = 0;
      table_sb     = new();
      reset        = 1'b1;
      req_if.valid = 1'b0;
      req_if.func  = cht_pkg::FN_ADD;
      req_if.sign_high = '0;
      req_if.sign_low  = '0;
      req_if.code_in   = '0;
      req_if.value_in  = '0;
      rsp_if.ready = 1'b0;
      csr_if.valid = 1'b0;
      csr_if.bucket_count = 13'd4096;
      foreach (key_pool_hi[i]) begin
         key_pool_hi[i] = $urandom();
         key_pool_lo[i] = $urandom();
      end
      key_pool_hi[0] = '0;  key_pool_lo[0] = '0;
      key_pool_hi[1] = '1;  key_pool_lo[1] = '1;
      key_pool_hi[2] = '1;  key_pool_lo[2] = 32'd1;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed: extremes, update, tombstone, revival, collisions, clear
      send_req(cht_pkg::FN_FIND, '0, '0, '0, '0);
      send_req(cht_pkg::FN_ADD, '0, '0, 32'h8000_0000, 32'h7fff_ffff);
      send_req(cht_pkg::FN_ADD, '1, '1, 32'h7fff_ffff, 32'h8000_0000);
      send_req(cht_pkg::FN_ADD, '1, 32'd1, '1, '0);
      send_req(cht_pkg::FN_ADD, 32'd1, '1, 32'd5, 32'd6);
      send_req(cht_pkg::FN_ADD, '0, '0, 32'd11, 32'd12);
      send_req(cht_pkg::FN_FIND, '0, '0, '0, '0);
      send_req(cht_pkg::FN_FIND, 32'd1, '1, '0, '0);
      send_req(cht_pkg::FN_FIND, '1, 32'd1, '0, '0);
      send_req(cht_pkg::FN_DELETE, '1, '1, '0, '0);
      send_req(cht_pkg::FN_FIND, '1, '1, '0, '0);
      send_req(cht_pkg::FN_DELETE, 32'h1234_5678, 32'h9abc_def0, '0, '0);
      send_req(cht_pkg::FN_ADD, '1, '1, 32'd77, 32'd88);
      send_req(cht_pkg::FN_FIND, '1, '1, '0, '0);
      send_req(cht_pkg::FN_CLEAR, '0, '0, '0, '0);
      send_req(cht_pkg::FN_FIND, '0, '0, '0, '0);
      send_req(cht_pkg::FN_DELETE, '0, '0, '0, '0);

      // bucket count extremes, plus zero and out-of-range values
      count_set[0] = 13'd1;
      count_set[1] = 13'd0;
      count_set[2] = 13'h1fff;
      count_set[3] = 13'd4096;
      count_set[4] = 13'd3;
      count_set[5] = 13'd4097;
      foreach (count_set[i]) begin
         write_bucket_count(count_set[i]);
         // every other phase keeps old entries, so they are not rehashed
         if (i % 2 == 0) send_req(cht_pkg::FN_CLEAR, '0, '0, '0, '0);
         random_phase(80);
      end
      write_bucket_count(13'($urandom_range(2, 4095)));
      random_phase(200);

      wait_idle();
      $display("%0d requests sent, %0d results checked, bucket counts 0 to 8191,",
               sent, table_sb.checked);
      $display("tombstones, same-bucket collisions and clears with stalls on both sides");
      if (table_sb.errors == 0 && table_sb.pending() == 0) begin
         $display("tb_chained_hash_table_engine OK");
      end else begin
         $display("%0d mismatches, %0d results missing", table_sb.errors, table_sb.pending());
         $display("tb_chained_hash_table_engine NOT OK");
      end
      $finish;
   end
endmodule
